// ----- design/ncr_pkg.sv -----
// Package for the Newton cubic root finder.
// Fixed-point widths, register indexes and shared payload types. No dependencies.
package ncr_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int MAX_ITER  = 64;
  localparam int COUNT_W   = 7;
  localparam int TOL_W     = 31;
  localparam int CFG_IDX_W = 1;

  typedef logic signed [DATA_W-1:0] q_t;
  typedef logic [COUNT_W-1:0]       count_t;
  typedef logic [TOL_W-1:0]         tol_t;
  typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;

  localparam cfg_idx_t REG_TOLERANCE  = 1'd0;
  localparam cfg_idx_t REG_ITER_LIMIT = 1'd1;

  localparam tol_t   TOL_RESET   = 31'd66;
  localparam count_t LIMIT_RESET = 7'd20;

endpackage

// ----- design/ncr_in_if.sv -----
// Input channel of the Newton cubic root finder: one starting guess per item.
// Depends on ncr_pkg.
interface ncr_in_if;
  import ncr_pkg::*;

  logic valid;
  logic ready;
  q_t   initial_guess;

  modport source (output valid, output initial_guess, input ready);
  modport sink   (input valid, input initial_guess, output ready);
endinterface

// ----- design/ncr_out_if.sv -----
// Result channel of the Newton cubic root finder: one item per iteration.
// Depends on ncr_pkg.
interface ncr_out_if;
  import ncr_pkg::*;

  logic   valid;
  logic   ready;
  count_t iteration_number;
  q_t     estimate;
  q_t     residual;
  logic   converged;
  logic   derivative_zero;
  logic   last_of_run;

  modport source (output valid, output iteration_number, output estimate, output residual,
                  output converged, output derivative_zero, output last_of_run, input ready);
  modport sink   (input valid, input iteration_number, input estimate, input residual,
                  input converged, input derivative_zero, input last_of_run, output ready);
endinterface

// ----- design/newton_cubic_root_finder_unit.sv -----
// Newton-Raphson root finder for x^3 - 2x - 5 in signed Q16.16, top level.
// Depends on ncr_pkg, ncr_in_if and ncr_out_if.
//
// Each input item is a starting guess; the block emits one result item per
// iteration until the step falls below tolerance, the iteration limit is hit,
// or the derivative is zero. One signed 32x32 multiplier is shared by the
// square and cube products, and the quotient f/f' comes from a restoring
// divider that retires one bit per cycle of its 48-bit quotient. A new guess
// is taken only when the previous run is finished; the final result may still
// sit in the output register at that time.
module newton_cubic_root_finder_unit (
  input  logic              clk,
  input  logic              rst,
  ncr_in_if.sink            req,
  ncr_out_if.source         rsp,
  input  logic              cfg_we,
  input  ncr_pkg::cfg_idx_t cfg_index,
  input  ncr_pkg::tol_t     cfg_data
);
  import ncr_pkg::*;

  localparam int NUM_W  = DATA_W + FRAC_BITS;
  localparam int DCNT_W = $clog2(NUM_W);
  localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(NUM_W - 1);

  localparam logic signed [63:0] W_MAX  = 64'sd2147483647;
  localparam logic signed [63:0] W_MIN  = -64'sd2147483648;
  localparam logic signed [63:0] FIVE_Q = 64'sd5 <<< FRAC_BITS;
  localparam logic signed [63:0] TWO_Q  = 64'sd2 <<< FRAC_BITS;
  localparam q_t Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam q_t Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQ   = 4'd1;
  localparam logic [3:0] S_SQW  = 4'd2;
  localparam logic [3:0] S_CUBE = 4'd3;
  localparam logic [3:0] S_EVAL = 4'd4;
  localparam logic [3:0] S_CHK  = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_STEP = 4'd7;
  localparam logic [3:0] S_EMIT = 4'd8;

  function automatic logic signed [63:0] sx(input q_t v);
    return {{(64-DATA_W){v[DATA_W-1]}}, v};
  endfunction

  function automatic q_t sat_q(input logic signed [63:0] v);
    if (v > W_MAX) return Q_MAX;
    if (v < W_MIN) return Q_MIN;
    return q_t'(v[DATA_W-1:0]);
  endfunction

  logic [3:0]              state;
  q_t                      x, sq, fx, dfx;
  logic signed [63:0]      prod;
  count_t                  count, lim;
  logic                    first, zero, conv, neg;
  logic [NUM_W-1:0]        num;
  logic [DATA_W:0]         rem;
  logic [DATA_W-1:0]       den;
  logic [DCNT_W-1:0]       dcnt;
  tol_t                    tolerance;
  count_t                  iteration_limit;

  logic                    out_valid, out_conv, out_dz, out_last;
  count_t                  out_iter;
  q_t                      out_est, out_res;

  q_t                      mul_a, mul_b, prod_q, twice, fx_new, dfx_new, step, next_x;
  logic [DATA_W-1:0]       fx_mag, dfx_mag;
  logic [DATA_W:0]         rem_sh;
  logic                    ge, can_load, res_last, q_over;
  logic signed [63:0]      diff;
  logic [63:0]             diff_abs;
  count_t                  lim_in;

  assign req.ready            = (state == S_IDLE);
  assign rsp.valid            = out_valid;
  assign rsp.iteration_number = out_iter;
  assign rsp.estimate         = out_est;
  assign rsp.residual         = out_res;
  assign rsp.converged        = out_conv;
  assign rsp.derivative_zero  = out_dz;
  assign rsp.last_of_run      = out_last;

  always_comb begin
    mul_a = x;
    mul_b = x;
    if (state == S_CUBE) begin
      mul_a = sq;
    end
  end

  always_comb begin
    prod_q  = sat_q(prod >>> FRAC_BITS);
    twice   = sat_q(sx(x) <<< 1);
    fx_new  = sat_q(sx(prod_q) - sx(twice) - FIVE_Q);
    dfx_new = sat_q(sx(sq) + (sx(sq) <<< 1) - TWO_Q);
    fx_mag  = fx[DATA_W-1] ? (~fx + 1'b1) : fx;
    dfx_mag = dfx[DATA_W-1] ? (~dfx + 1'b1) : dfx;
  end

  always_comb begin
    rem_sh = {rem[DATA_W-1:0], num[NUM_W-1]};
    ge     = (rem_sh >= {1'b0, den});
  end

  always_comb begin
    if (neg) begin
      q_over = (|num[NUM_W-1:DATA_W]) || (num[DATA_W-1] && (|num[DATA_W-2:0]));
      step   = q_over ? Q_MIN : q_t'(~num[DATA_W-1:0] + 1'b1);
    end else begin
      q_over = |num[NUM_W-1:DATA_W-1];
      step   = q_over ? Q_MAX : q_t'(num[DATA_W-1:0]);
    end
    next_x   = sat_q(sx(x) - sx(step));
    diff     = sx(next_x) - sx(x);
    diff_abs = diff[63] ? 64'(-diff) : 64'(diff);
  end

  always_comb begin
    lim_in = iteration_limit;
    if (iteration_limit == '0) begin
      lim_in = count_t'(1);
    end else if (iteration_limit > count_t'(MAX_ITER)) begin
      lim_in = count_t'(MAX_ITER);
    end
  end

  assign can_load = !out_valid || rsp.ready;
  assign res_last = zero || conv || (count >= lim);

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance       <= TOL_RESET;
      iteration_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TOLERANCE:  tolerance <= cfg_data;
        REG_ITER_LIMIT: iteration_limit <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            x     <= req.initial_guess;
            count <= '0;
            lim   <= lim_in;
            first <= 1'b1;
            zero  <= 1'b0;
            conv  <= 1'b0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          prod  <= mul_a * mul_b;
          state <= S_SQW;
        end
        S_SQW: begin
          sq    <= prod_q;
          state <= S_CUBE;
        end
        S_CUBE: begin
          prod  <= mul_a * mul_b;
          state <= S_EVAL;
        end
        S_EVAL: begin
          fx    <= fx_new;
          dfx   <= dfx_new;
          state <= first ? S_CHK : S_EMIT;
        end
        S_CHK: begin
          if (dfx == '0) begin
            zero  <= 1'b1;
            count <= count + 1'b1;
            state <= S_EMIT;
          end else begin
            den   <= dfx_mag;
            num   <= {fx_mag, {FRAC_BITS{1'b0}}};
            rem   <= '0;
            dcnt  <= '0;
            neg   <= fx[DATA_W-1] ^ dfx[DATA_W-1];
            state <= S_DIV;
          end
        end
        S_DIV: begin
          num <= {num[NUM_W-2:0], ge};
          rem <= ge ? (rem_sh - {1'b0, den}) : rem_sh;
          if (dcnt == DCNT_LAST) begin
            state <= S_STEP;
          end else begin
            dcnt <= dcnt + 1'b1;
          end
        end
        S_STEP: begin
          x     <= next_x;
          conv  <= (diff_abs < {{(64-TOL_W){1'b0}}, tolerance});
          count <= count + 1'b1;
          first <= 1'b0;
          state <= S_SQ;
        end
        S_EMIT: begin
          if (can_load) begin
            out_valid <= 1'b1;
            out_iter  <= count;
            out_est   <= x;
            out_res   <= fx;
            out_conv  <= conv & ~zero;
            out_dz    <= zero;
            out_last  <= res_last;
            state     <= res_last ? S_IDLE : S_CHK;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state == S_SQ && count == '0))
    else $error("run did not start cleanly after an accepted item");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (count <= lim))
    else $error("iteration count passed the run limit");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && can_load && res_last) |=> (state == S_IDLE))
    else $error("run kept going after its last item");

  a_zero_flags: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_dz) |-> (out_last && !out_conv))
    else $error("zero-derivative item not marked as final");

endmodule
